// ===== sv/wildcard_glob_matcher_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the glob matcher
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH

// expression must hold at every edge out of reset
`define WGM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wgm_pkg.sv =====
// ---------------------------------------------------------------------------
// Glob matcher package
// Character codes, action codes, cell interface types and case folding.
// ---------------------------------------------------------------------------
package wgm_pkg;

    localparam logic [7:0] CH_ANY     = 8'h3F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_ALT     = 8'h7C;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_NAME    = 1'b1;

    typedef struct packed {
        logic       clr;
        logic       adv;
        logic       nip;
        logic       alt;
        logic       fold_en;
        logic [7:0] fold_b;
        logic [7:0] wr_byte;
    } t_cell_ctrl;

    typedef struct packed {
        logic raw;
        logic star;
        logic is_alt;
        logic valid;
        logic boundary;
        logic fwd;
    } t_cell_stat;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ===== sv/wgm_cell.sv =====
// ---------------------------------------------------------------------------
// Glob matcher cell
// One pattern position: stored byte, valid flag and active bit.
// ---------------------------------------------------------------------------
module wgm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wgm_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_wr,
    input  logic                i_start,
    input  logic                i_fwd,
    input  logic                i_closed,
    output wgm_pkg::t_cell_stat o_stat
);
    import wgm_pkg::*;

    logic [7:0] r_byte;
    logic       r_valid;
    logic       r_active;
    logic       n_active;
    logic       stay;
    logic       live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_valid <= 1'b0;
            end
            if (i_wr) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_ctrl.wr_byte;
        end
        if (i_ctrl.adv) begin
            r_active <= n_active;
        end
    end

    always_comb begin
        o_stat.valid    = r_valid;
        o_stat.star     = r_valid && (r_byte == CH_STAR);
        o_stat.is_alt   = r_byte == CH_ALT;
        o_stat.boundary = !r_valid || (i_ctrl.alt && r_byte == CH_ALT);
        o_stat.raw      = i_ctrl.nip ? r_active : i_start;
        live            = i_closed && !o_stat.boundary;
        stay            = live && (r_byte == CH_STAR);
        o_stat.fwd      = live && (r_byte != CH_STAR) && ((r_byte == CH_ANY) ||
                          (fold_byte(r_byte, i_ctrl.fold_en) == i_ctrl.fold_b));
        n_active        = stay || i_fwd;
    end

endmodule

// ===== sv/wgm_star_close.sv =====
// ---------------------------------------------------------------------------
// Glob matcher star closure
// Carry-chain closure: each active star also activates the next position.
// ---------------------------------------------------------------------------
module wgm_star_close #(
    parameter int W = 65
) (
    input  logic [W-1:0] i_raw,
    input  logic [W-1:0] i_star,
    output logic [W-1:0] o_closed
);
    logic [W-1:0] gen;
    logic [W-1:0] sum;
    logic [W-1:0] carry;

    always_comb begin
        gen      = i_raw & i_star;
        sum      = gen + i_star;
        carry    = sum ^ gen ^ i_star;
        o_closed = i_raw | carry;
    end

endmodule

// ===== sv/wildcard_glob_matcher_top.sv =====
// ---------------------------------------------------------------------------
// Wildcard glob matcher
// Streams pattern and name bytes through a row of position cells; a zero
// name byte yields one match/overflow result.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | i_in_valid / o_in_stall | i_action, i_byte_value
//  out     | source    | o_out_valid / i_out_stall | o_match, o_overflow
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_data (fold_case)
//
//  One input beat per cycle while not stalled; each result is registered.
//  The rate is set by the per-cycle active-bit update across all cells plus the
//  star closure carry chain.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A two-entry output stage holds results; input stalls only when both are full.
// ---------------------------------------------------------------------------
`include "wildcard_glob_matcher_top_macros.svh"

module wildcard_glob_matcher_top #(
    parameter int MAX_PATTERN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_match,
    output logic       o_overflow,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import wgm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int W  = MAX_PATTERN + 1;

    logic          r_fold_case;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_loading;
    logic          r_nip;
    logic          r_tail;

    logic          r_out_valid;
    logic          r_out_match;
    logic          r_out_ovf;
    logic          r_skid_valid;
    logic          r_skid_match;
    logic          r_skid_ovf;

    logic          in_acc;
    logic          is_pat;
    logic          is_name;
    logic          byte_zero;
    logic [LW-1:0] eff_len;
    logic          eff_ovf;
    logic          do_store;
    logic          res_valid;
    logic          res_match;
    logic          out_take;
    logic          accept;

    t_cell_ctrl        ctrl;
    t_cell_stat        stat   [MAX_PATTERN];
    logic [W-1:0]      raw_vec;
    logic [W-1:0]      star_vec;
    logic [W-1:0]      closed;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] wr_en;
    logic [MAX_PATTERN-1:0] start_bit;
    logic [MAX_PATTERN-1:0] fwd_in;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_match     = r_out_match;
    assign o_overflow  = r_out_ovf;

    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        is_pat    = in_acc && (i_action == ACT_PATTERN);
        is_name   = in_acc && (i_action == ACT_NAME);
        byte_zero = i_byte_value == CH_NUL;
        eff_len   = r_loading ? r_len : '0;
        eff_ovf   = r_loading && r_ovf;
        do_store  = is_pat && !byte_zero && (eff_len < LW'(MAX_PATTERN));

        ctrl.clr     = is_pat && !r_loading;
        ctrl.adv     = is_name && !byte_zero;
        ctrl.nip     = r_nip;
        ctrl.alt     = (r_len != '0) && stat[0].is_alt;
        ctrl.fold_en = r_fold_case;
        ctrl.fold_b  = fold_byte(i_byte_value, r_fold_case);
        ctrl.wr_byte = i_byte_value;
    end

    for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
        assign wr_en[p] = do_store && (eff_len == LW'(p));
        if (p == 0) begin : g_first
            assign start_bit[p] = !ctrl.alt;
            assign fwd_in[p]    = 1'b0;
        end else begin : g_rest
            assign start_bit[p] = ctrl.alt && stat[p].valid && stat[p-1].is_alt;
            assign fwd_in[p]    = stat[p-1].fwd;
        end

        wgm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_wr     (wr_en[p]),
            .i_start  (start_bit[p]),
            .i_fwd    (fwd_in[p]),
            .i_closed (closed[p]),
            .o_stat   (stat[p])
        );

        assign raw_vec[p]  = stat[p].raw;
        assign star_vec[p] = stat[p].star;
        assign hit[p]      = closed[p] && stat[p].boundary;
    end

    assign raw_vec[MAX_PATTERN]  = r_nip && r_tail;
    assign star_vec[MAX_PATTERN] = 1'b0;

    wgm_star_close #(.W(W)) u_close (
        .i_raw    (raw_vec),
        .i_star   (star_vec),
        .o_closed (closed)
    );

    always_comb begin
        accept    = (|hit) || closed[MAX_PATTERN];
        res_valid = is_name && byte_zero;
        res_match = !r_ovf && accept;
        out_take  = r_out_valid && !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fold_case <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_loading <= 1'b0;
            r_nip     <= 1'b0;
        end else if (is_pat) begin
            r_loading <= !byte_zero;
            r_len     <= do_store ? eff_len + LW'(1) : eff_len;
            r_ovf     <= eff_ovf || (!byte_zero && !do_store);
            r_nip     <= 1'b0;
        end else if (is_name) begin
            r_loading <= 1'b0;
            r_nip     <= !byte_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.adv) begin
            r_tail <= stat[MAX_PATTERN-1].fwd;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_match  <= r_skid_match;
                    r_out_ovf    <= r_skid_ovf;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                    r_out_match <= res_match;
                    r_out_ovf   <= r_ovf;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
                r_skid_match <= res_match;
                r_skid_ovf   <= r_ovf;
            end
        end
    end

    `WGM_ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid, "skid entry without output entry")
    `WGM_ASSERT_ALWAYS(a_ovf_no_match, i_clk, i_rst_n, !(r_out_valid && r_out_ovf && r_out_match), "match reported with overflow")
    `WGM_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= LW'(MAX_PATTERN), "pattern length beyond store")
    `WGM_ASSERT_ALWAYS(a_load_name_excl, i_clk, i_rst_n, !(r_loading && r_nip), "pattern load and name both active")
    `WGM_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, res_valid, r_out_valid, "result beat lost")

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// Glob matcher testbench
// Loads patterns and streams names through the matcher, predicts each
// match/overflow verdict with an in-bench position-set matcher, and compares
// every output beat in order, across fold settings and idle/stall mixes.
// ---------------------------------------------------------------------------
module testbench;
    import wgm_pkg::*;

    localparam int MAX_PAT     = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;
    localparam int PHASE_BEATS = 220;

    typedef struct packed {
        logic match;
        logic overflow;
    } verdict_t;

    typedef logic [7:0] byte_q_t [$];

    class match_scoreboard;
        bit             fold_case;
        logic [7:0]     pat_mem [MAX_PAT];
        int             pat_len;
        bit [MAX_PAT:0] live;
        bit             in_name;
        bit             overflowed;
        bit             loading;
        verdict_t       pending_verdicts [$];
        int             failures;

        function new();
            fold_case  = 1'b1;
            pat_len    = 0;
            live       = '0;
            in_name    = 1'b0;
            overflowed = 1'b0;
            loading    = 1'b0;
            failures   = 0;
            foreach (pat_mem[k]) pat_mem[k] = CH_NUL;
        endfunction

        function logic [7:0] to_upper(input logic [7:0] c);
            if (fold_case && c >= CH_LOW_A && c <= CH_LOW_Z) begin
                return c - CASE_DELTA;
            end
            return c;
        endfunction

        function bit alt_list();
            return pat_len > 0 && pat_mem[0] == CH_ALT;
        endfunction

        function bit is_stop(input int p, input bit alt);
            if (p >= pat_len) begin
                return 1'b1;
            end
            return alt && pat_mem[p] == CH_ALT;
        endfunction

        function bit [MAX_PAT:0] star_close(input bit [MAX_PAT:0] s);
            int p;
            for (p = 0; p < pat_len; p++) begin
                if (s[p] && pat_mem[p] == CH_STAR) s[p+1] = 1'b1;
            end
            return s;
        endfunction

        function void open_name();
            int p;
            live = '0;
            if (!alt_list()) begin
                live[0] = 1'b1;
            end else begin
                for (p = 0; p < pat_len; p++) begin
                    if (pat_mem[p] == CH_ALT && p + 1 < pat_len) live[p+1] = 1'b1;
                end
            end
            live    = star_close(live);
            in_name = 1'b1;
        endfunction

        function void step_name(input logic [7:0] b);
            bit [MAX_PAT:0] nxt;
            bit             alt;
            int             p;
            logic [7:0]     c;
            nxt = '0;
            alt = alt_list();
            for (p = 0; p < pat_len; p++) begin
                if (!live[p] || is_stop(p, alt)) continue;
                c = pat_mem[p];
                if (c == CH_STAR) begin
                    nxt[p] = 1'b1;
                end else if (c == CH_ANY || to_upper(c) == to_upper(b)) begin
                    nxt[p+1] = 1'b1;
                end
            end
            live = star_close(nxt);
        endfunction

        function bit name_hit();
            bit alt;
            int p;
            alt = alt_list();
            for (p = 0; p <= pat_len; p++) begin
                if (live[p] && is_stop(p, alt)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_beat(input logic act, input logic [7:0] b);
            verdict_t v;
            if (act == ACT_PATTERN) begin
                if (!loading) begin
                    loading    = 1'b1;
                    pat_len    = 0;
                    overflowed = 1'b0;
                    in_name    = 1'b0;
                    live       = '0;
                end
                if (b == CH_NUL) begin
                    loading = 1'b0;
                end else if (pat_len < MAX_PAT) begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end else begin
                    overflowed = 1'b1;
                end
            end else begin
                loading = 1'b0;
                if (!in_name) open_name();
                if (b != CH_NUL) begin
                    step_name(b);
                end else begin
                    v.match    = !overflowed && name_hit();
                    v.overflow = overflowed;
                    pending_verdicts.push_back(v);
                    in_name = 1'b0;
                    live    = '0;
                end
            end
        endfunction

        function void check_result(input logic m, input logic ov);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected beat: match=%b overflow=%b", m, ov);
                end
                return;
            end
            want = pending_verdicts.pop_front();
            if (m !== want.match || ov !== want.overflow) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected match=%b overflow=%b, got match=%b overflow=%b",
                             want.match, want.overflow, m, ov);
                end
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_action;
    logic [7:0] i_byte_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_match;
    logic       o_overflow;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    match_scoreboard board;
    int              sender_idle_pct;
    int              recv_stall_pct;
    int              beats_sent;
    int              cycle_count = 0;

    int idle_tab  [4] = '{0, 81, 0, 24};
    int stall_tab [4] = '{0, 0, 81, 24};
    bit fold_tab  [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

    wildcard_glob_matcher_top #(
        .MAX_PATTERN(MAX_PAT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_match      (o_match),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_match, o_overflow);
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_in_stall);
        board.note_beat(act, b);
        beats_sent++;
    endtask

    task automatic send_text(input logic act, input string s, input bit term);
        int k;
        for (k = 0; k < s.len(); k++) send_beat(act, s[k]);
        if (term) send_beat(act, CH_NUL);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_fold(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.fold_case = v;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CH_LOW_A + 8'($urandom_range(0, 3));
        if ($urandom_range(1)) c = c - CASE_DELTA;
        return c;
    endfunction

    function automatic logic [7:0] pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 50) return rand_letter();
        if (r < 65) return CH_STAR;
        if (r < 78) return CH_ANY;
        if (r < 86) return CH_ALT;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void make_name(input byte_q_t pat, output byte_q_t name);
        int         from;
        int         k;
        int         bars [$];
        bit         alt;
        logic [7:0] c;
        name = {};
        if ($urandom_range(1)) begin
            alt  = pat.size() > 0 && pat[0] == CH_ALT;
            from = 0;
            if (alt) begin
                foreach (pat[j]) if (pat[j] == CH_ALT) bars.push_back(j);
                from = bars[$urandom_range(bars.size() - 1)] + 1;
            end
            for (k = from; k < pat.size(); k++) begin
                c = pat[k];
                if (alt && c == CH_ALT) break;
                case (c)
                    CH_STAR: begin
                        repeat ($urandom_range(0, 2)) name.push_back(rand_letter());
                    end
                    CH_ANY: begin
                        name.push_back(8'($urandom_range(1, 255)));
                    end
                    default: begin
                        if ((c | CASE_DELTA) >= CH_LOW_A && (c | CASE_DELTA) <= CH_LOW_Z
                            && $urandom_range(1)) begin
                            c = c ^ CASE_DELTA;
                        end
                        name.push_back(c);
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(9) == 0) name.push_back(8'($urandom_range(1, 255)));
                else name.push_back(rand_letter());
            end
        end
    endfunction

    task automatic glob_session();
        byte_q_t pat_q;
        byte_q_t name_q;
        int      plen;
        pat_q = {};
        if ($urandom_range(24) == 0) plen = $urandom_range(MAX_PAT - 4, MAX_PAT + 6);
        else plen = $urandom_range(0, 7);
        if ($urandom_range(9) < 3) pat_q.push_back(CH_ALT);
        while (pat_q.size() < plen) pat_q.push_back(pattern_char());
        foreach (pat_q[k]) send_beat(ACT_PATTERN, pat_q[k]);
        if ($urandom_range(9) != 0) send_beat(ACT_PATTERN, CH_NUL);
        repeat ($urandom_range(1, 4)) begin
            make_name(pat_q, name_q);
            foreach (name_q[k]) send_beat(ACT_NAME, name_q[k]);
            if ($urandom_range(11) != 0) send_beat(ACT_NAME, CH_NUL);
        end
    endtask

    task automatic random_traffic(input int quota);
        int start_cnt;
        start_cnt = beats_sent;
        while (beats_sent - start_cnt < quota) begin
            if ($urandom_range(99) < 12) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(3) == 0) send_beat(1'($urandom_range(1)), CH_NUL);
                    else send_beat(1'($urandom_range(1)), 8'($urandom_range(0, 255)));
                end
            end else begin
                glob_session();
            end
        end
    endtask

    initial begin
        int ph;
        board           = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        beats_sent      = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_PATTERN;
        i_byte_value <= CH_NUL;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= 1'b0;
        i_out_stall  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text(ACT_PATTERN, "a*?Z", 1'b1);
        send_text(ACT_NAME, "AqrZ", 1'b1);
        send_text(ACT_NAME, "", 1'b1);
        send_text(ACT_NAME, "A", 1'b0);
        send_text(ACT_PATTERN, "|ab||", 1'b1);
        send_text(ACT_NAME, "", 1'b1);
        send_text(ACT_PATTERN, "|", 1'b1);
        send_text(ACT_NAME, "", 1'b1);
        send_beat(ACT_PATTERN, 8'hFF);
        send_beat(ACT_NAME, 8'hFF);
        send_beat(ACT_NAME, CH_NUL);
        drain();

        for (ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_tab[ph];
            recv_stall_pct  = stall_tab[ph];
            write_fold(fold_tab[ph]);
            random_traffic(PHASE_BEATS);
            drain();
        end

        if (board.pending() != 0) board.failures++;
        if (board.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
